@@ rtl/core/sfre_pkg.sv @@
// shared constants, types and helpers of the resonator envelope core
package sfre_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int STATE_BITS    = 28;
    localparam int COEF_BITS     = 18;
    localparam int FRAC_BITS     = 16;
    localparam int POWER_BITS    = 56;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = COEF_BITS;
    localparam int DIFF_BITS     = SAMPLE_BITS + 1;
    localparam int PROD_BITS     = 2 * STATE_BITS;
    localparam int ACC_BITS      = PROD_BITS + 1;
    localparam int SUM_BITS      = ACC_BITS - FRAC_BITS + 1;

    localparam logic [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) << (FRAC_BITS - 1);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_COEF_COS      = 2'd0,
        CFG_COEF_SIN      = 2'd1,
        CFG_DIFFERENTIATE = 2'd2
    } t_cfg_index;

    function automatic logic signed [STATE_BITS-1:0] sat_state(
        input logic signed [SUM_BITS-1:0] v
    );
        logic [SUM_BITS-STATE_BITS:0] top;
        logic signed [STATE_BITS-1:0] res;
        top = v[SUM_BITS-1:STATE_BITS-1];
        if ((&top) || (~|top)) begin
            res = v[STATE_BITS-1:0];
        end else if (v[SUM_BITS-1]) begin
            res = {1'b1, {(STATE_BITS-1){1'b0}}};
        end else begin
            res = {1'b0, {(STATE_BITS-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

@@ rtl/core/sfre_in_if.sv @@
// input item channel: audio sample and first-sample flag
interface sfre_in_if import sfre_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          first_sample;

    modport source (output valid, output sample, output first_sample, input ready);
    modport sink (input valid, input sample, input first_sample, output ready);
endinterface

@@ rtl/core/sfre_out_if.sv @@
// result item channel: resonator state and envelope power
interface sfre_out_if import sfre_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [STATE_BITS-1:0] real_part;
    logic signed [STATE_BITS-1:0] imag_part;
    logic [POWER_BITS-1:0]        envelope_power;

    modport source (output valid, output real_part, output imag_part,
                    output envelope_power, input ready);
    modport sink (input valid, input real_part, input imag_part,
                  input envelope_power, output ready);
endinterface

@@ rtl/core/single_frequency_resonator_envelope_core.sv @@
// single-frequency complex resonator with envelope power, one shared multiplier
//
// i_in carries one signed audio sample per item plus a first-sample flag that
// clears the resonator and the previous sample before the item is used.
// o_out returns one item per input: new real and imaginary state (saturated)
// and re^2 + im^2. coefficients and the differencing switch are written on
// the cfg port (index 0 cos, 1 sin, 2 differentiate); the user must write
// them only while the core is idle, as the core itself does not enforce it.
// one 28x28 signed multiplier is reused under a sequencer: four products for
// the resonator update, then two squares for the power, through states
// ST_CR to ST_PS; the result is then valid in ST_OUT. i_in.ready is high
// only while the core is idle. if the sink stalls, the result is held
// unchanged in place and no new item is taken until it is delivered.
// synchronous reset clears the coefficients, sets differencing on, zeroes
// the filter state and previous sample, and leaves the core idle and ready.
module single_frequency_resonator_envelope_core import sfre_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    sfre_in_if.sink                  i_in,
    sfre_out_if.source               o_out
);

    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_CR   = 10'b00_0000_0010,
        ST_SI   = 10'b00_0000_0100,
        ST_CI   = 10'b00_0000_1000,
        ST_SR   = 10'b00_0001_0000,
        ST_RR   = 10'b00_0010_0000,
        ST_IW   = 10'b00_0100_0000,
        ST_II   = 10'b00_1000_0000,
        ST_PS   = 10'b01_0000_0000,
        ST_OUT  = 10'b10_0000_0000
    } t_state;

    t_state                        r_state, n_state;
    logic signed [COEF_BITS-1:0]   r_coef_cos;
    logic signed [COEF_BITS-1:0]   r_coef_sin;
    logic                          r_diff;
    logic signed [SAMPLE_BITS-1:0] r_prev;
    logic signed [STATE_BITS-1:0]  r_re;
    logic signed [STATE_BITS-1:0]  r_im;
    logic signed [DIFF_BITS-1:0]   r_d;
    logic signed [PROD_BITS-1:0]   r_prod;
    logic signed [ACC_BITS-1:0]    r_acc;

    logic                          in_acc;
    logic signed [SAMPLE_BITS-1:0] prev_eff;
    logic signed [DIFF_BITS-1:0]   d_val;
    logic signed [STATE_BITS-1:0]  cos_ext, sin_ext;
    logic signed [STATE_BITS-1:0]  mul_a, mul_b;
    logic signed [PROD_BITS-1:0]   product;
    logic signed [ACC_BITS-1:0]    prod_ext;
    logic [ACC_BITS-1:0]           rnd;
    logic signed [SUM_BITS-2:0]    shifted;
    logic signed [DIFF_BITS-1:0]   addend;
    logic signed [SUM_BITS-1:0]    state_sum;
    logic signed [STATE_BITS-1:0]  state_sat;

    assign in_acc      = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign o_out.valid = (r_state == ST_OUT);
    assign o_out.real_part      = r_re;
    assign o_out.imag_part      = r_im;
    assign o_out.envelope_power = r_acc[POWER_BITS-1:0];

    assign prev_eff = i_in.first_sample ? '0 : r_prev;
    assign d_val    = r_diff ? (DIFF_BITS'(i_in.sample) - DIFF_BITS'(prev_eff))
                             : DIFF_BITS'(i_in.sample);

    assign cos_ext = {{(STATE_BITS-COEF_BITS){r_coef_cos[COEF_BITS-1]}}, r_coef_cos};
    assign sin_ext = {{(STATE_BITS-COEF_BITS){r_coef_sin[COEF_BITS-1]}}, r_coef_sin};

    always_comb begin
        case (r_state)
            ST_CR: begin
                mul_a = cos_ext;
                mul_b = r_re;
            end
            ST_SI: begin
                mul_a = sin_ext;
                mul_b = r_im;
            end
            ST_CI: begin
                mul_a = cos_ext;
                mul_b = r_im;
            end
            ST_SR: begin
                mul_a = sin_ext;
                mul_b = r_re;
            end
            ST_II: begin
                mul_a = r_im;
                mul_b = r_im;
            end
            default: begin
                mul_a = r_re;
                mul_b = r_re;
            end
        endcase
    end

    assign product  = mul_a * mul_b;
    assign prod_ext = ACC_BITS'(r_prod);

    // round half up, floor shift, add drive term on the real step, saturate
    assign rnd       = r_acc + ROUND_HALF;
    assign shifted   = rnd[ACC_BITS-1:FRAC_BITS];
    assign addend    = (r_state == ST_SR) ? r_d : '0;
    assign state_sum = SUM_BITS'(shifted) + SUM_BITS'(addend);
    assign state_sat = sat_state(state_sum);

    always_comb begin
        case (r_state)
            ST_IDLE: n_state = in_acc ? ST_CR : ST_IDLE;
            ST_CR:   n_state = ST_SI;
            ST_SI:   n_state = ST_CI;
            ST_CI:   n_state = ST_SR;
            ST_SR:   n_state = ST_RR;
            ST_RR:   n_state = ST_IW;
            ST_IW:   n_state = ST_II;
            ST_II:   n_state = ST_PS;
            ST_PS:   n_state = ST_OUT;
            ST_OUT:  n_state = o_out.ready ? ST_IDLE : ST_OUT;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_coef_cos <= '0;
            r_coef_sin <= '0;
            r_diff     <= 1'b1;
            r_prev     <= '0;
            r_re       <= '0;
            r_im       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_COEF_COS:      r_coef_cos <= i_cfg_data[COEF_BITS-1:0];
                    CFG_COEF_SIN:      r_coef_sin <= i_cfg_data[COEF_BITS-1:0];
                    CFG_DIFFERENTIATE: r_diff     <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_prev <= i_in.sample;
                if (i_in.first_sample) begin
                    r_re <= '0;
                    r_im <= '0;
                end
            end
            if (r_state == ST_SR) begin
                r_re <= state_sat;
            end
            if (r_state == ST_IW) begin
                r_im <= state_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= product;
        if (in_acc) begin
            r_d <= d_val;
        end
        case (r_state)
            ST_SI, ST_SR, ST_IW: r_acc <= prod_ext;
            ST_CI:               r_acc <= r_acc - prod_ext;
            ST_RR, ST_PS:        r_acc <= r_acc + prod_ext;
            default: ;
        endcase
    end

endmodule

@@ rtl/core/sfre_checker.sv @@
// port-level checks of the resonator envelope core and their binding
module sfre_checker import sfre_pkg::*; (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic signed [STATE_BITS-1:0] i_real_part,
    input logic signed [STATE_BITS-1:0] i_imag_part,
    input logic [POWER_BITS-1:0]        i_envelope_power
);

    logic in_acc, out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready while a result item is pending");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_out_valid)
        else $error("result item shown right after input accept");

    a_ready_after_delivery: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |=> i_in_ready)
        else $error("core not ready after result item delivered");

    a_zero_power: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_real_part == '0 && i_imag_part == '0) |-> i_envelope_power == '0)
        else $error("nonzero power for zero state");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_real_part) && $stable(i_imag_part)
             && $stable(i_envelope_power)))
        else $error("stalled result item changed");

endmodule

bind single_frequency_resonator_envelope_core sfre_checker u_sfre_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_real_part      (o_out.real_part),
    .i_imag_part      (o_out.imag_part),
    .i_envelope_power (o_out.envelope_power)
);
